// File: hdl/cfh_pkg.sv
package cfh_pkg;

  // Item modes.
  localparam logic [1:0] MODE_DC    = 2'd0;
  localparam logic [1:0] MODE_AC    = 2'd1;
  localparam logic [1:0] MODE_EOB   = 2'd2;
  localparam logic [1:0] MODE_FLUSH = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Saturation limits.
  localparam logic signed [15:0] DC_MAX = 16'sd2047;
  localparam logic signed [15:0] AC_MAX = 16'sd1023;

  // Zero-run code (symbol 0xF0) and end-of-block code (symbol 0x00).
  localparam logic [15:0] ZRL_CODE = 16'b0000011111111001;
  localparam logic [4:0]  ZRL_LEN  = 5'd11;
  localparam logic [7:0]  SYM_EOB  = 8'h00;
  localparam logic [7:0]  SYM_ZRL  = 8'hF0;

  // A table entry is {length, code}, code right aligned.
  typedef logic [20:0] hcode_t;
  typedef hcode_t ac_tab_t [0:255];
  typedef logic [7:0] ac_vals_t [0:161];
  typedef logic [7:0] ac_bits_t [0:15];

  localparam ac_bits_t AC_BITS = '{8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
                                   8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'd125};

  localparam ac_vals_t AC_VALS = '{
    8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,
    8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,8'h23,8'h42,8'hb1,8'hc1,
    8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,
    8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
    8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,
    8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,
    8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,
    8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
    8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,
    8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,
    8'hd9,8'hda,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,
    8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa
  };

  // Builds the canonical AC code table at elaboration, indexed by symbol.
  function automatic ac_tab_t build_ac_tab();
    ac_tab_t t;
    logic [15:0] c;
    int k;
    for (int i = 0; i < 256; i++) t[i] = '0;
    c = '0;
    k = 0;
    for (int l = 1; l <= 16; l++) begin
      for (int i = 0; i < int'(AC_BITS[l-1]); i++) begin
        t[AC_VALS[k]] = {5'(l), c};
        c = c + 16'd1;
        k = k + 1;
      end
      c = c << 1;
    end
    return t;
  endfunction

  localparam ac_tab_t AC_TAB = build_ac_tab();

  // DC luminance codes by category.
  function automatic hcode_t dc_code(input logic [3:0] cat);
    hcode_t r;
    case (cat)
      4'd0:    r = {5'd2, 16'b00};
      4'd1:    r = {5'd3, 16'b010};
      4'd2:    r = {5'd3, 16'b011};
      4'd3:    r = {5'd3, 16'b100};
      4'd4:    r = {5'd3, 16'b101};
      4'd5:    r = {5'd3, 16'b110};
      4'd6:    r = {5'd4, 16'b1110};
      4'd7:    r = {5'd5, 16'b11110};
      4'd8:    r = {5'd6, 16'b111110};
      4'd9:    r = {5'd7, 16'b1111110};
      4'd10:   r = {5'd8, 16'b11111110};
      4'd11:   r = {5'd9, 16'b111111110};
      default: r = '0;
    endcase
    return r;
  endfunction

  // One coded item as handed from the front to the back.
  typedef struct packed {
    logic [1:0]  n_zrl;
    logic [15:0] code;
    logic [4:0]  clen;
    logic [10:0] mag;
    logic [3:0]  mlen;
    logic        flush;
    logic [1:0]  status;
  } cfh_job_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
    logic [1:0] status;
  } cfh_res_t;

endpackage

// File: hdl/jpeg_coefficient_huffman_encoder.sv
// Channel   Ports                                         Handshake
// input     in_mode, in_zero_run, in_coef_value           push / full
// result    out_byte, out_has_byte, out_last, out_status  pop / empty
//
// The back end takes the job, then appends each code segment in turn (ZRL codes, prefix,
// magnitude, and the flush step even with nothing to pad), drains each completed byte as
// it forms, and ends the item with the last beat.
// Reset (rst_n low, synchronous) empties both queues and clears the bit buffer.
// The input side keeps accepting while the job queue has room; a stalled pop
// holds the packer once the result queue is full.
module jpeg_coefficient_huffman_encoder #(
  parameter int JOB_DEPTH = 4,
  parameter int RES_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_mode,
  input  logic [5:0]  in_zero_run,
  input  logic signed [15:0] in_coef_value,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_has_byte,
  output logic        out_last,
  output logic [1:0]  out_status
);
  import cfh_pkg::*;

  cfh_job_t job_w, job_q;
  cfh_res_t res_w, res_q;
  logic accept, job_empty, job_pop, res_full, res_push;

  assign accept = push && !full;

  cfh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .mode       (in_mode),
    .zero_run   (in_zero_run),
    .coef_value (in_coef_value),
    .job        (job_w)
  );

  cfh_fifo #(.W($bits(cfh_job_t)), .DEPTH(JOB_DEPTH)) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (job_w),
    .full  (full),
    .pop   (job_pop),
    .dout  (job_q),
    .empty (job_empty)
  );

  cfh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_in    (job_q),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_w)
  );

  cfh_fifo #(.W($bits(cfh_res_t)), .DEPTH(RES_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_w),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_q),
    .empty (empty)
  );

  assign out_byte     = res_q.data;
  assign out_has_byte = res_q.has_byte;
  assign out_last     = res_q.last;
  assign out_status   = res_q.status;
endmodule

// File: hdl/cfh_fifo.sv
module cfh_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem [0:DEPTH-1];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   count_r;
  logic do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  // Pointers wrap at the depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

// File: hdl/cfh_front.sv
module cfh_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        mode,
  input  logic [5:0]        zero_run,
  input  logic signed [15:0] coef_value,
  output cfh_pkg::cfh_job_t job
);
  import cfh_pkg::*;

  logic block_closed_r, block_closed_nxt;
  logic signed [15:0] lim, sv;
  logic sat;
  logic [10:0] mag_abs, mag_ones;
  logic [3:0] cat;
  logic [7:0] sym;
  hcode_t ac_hc, dc_hc, eob_hc;

  // Clamp to the category range of the table in use.
  always_comb begin
    lim = (mode == MODE_DC) ? DC_MAX : AC_MAX;
    sat = 1'b0;
    sv  = coef_value;
    if (coef_value > lim) begin
      sv  = lim;
      sat = 1'b1;
    end else if (coef_value < -lim) begin
      sv  = -lim;
      sat = 1'b1;
    end
  end

  // Category is the bit length of the magnitude; negatives go out as one's complement.
  always_comb begin
    mag_abs  = sv[15] ? 11'(-sv) : sv[10:0];
    mag_ones = sv[15] ? 11'(sv - 16'sd1) : sv[10:0];
    cat = 4'd0;
    for (int i = 0; i < 11; i++) begin
      if (mag_abs[i]) cat = 4'(i + 1);
    end
  end

  assign sym    = {zero_run[3:0], cat};
  assign ac_hc  = AC_TAB[sym];
  assign dc_hc  = dc_code(cat);
  assign eob_hc = AC_TAB[SYM_EOB];

  // Classify the item into ZRL count, prefix, magnitude bits, flush flag and status.
  always_comb begin
    job = '0;
    job.mag = mag_ones;
    block_closed_nxt = block_closed_r;
    case (mode)
      MODE_DC: begin
        block_closed_nxt = 1'b0;
        job.code   = dc_hc[15:0];
        job.clen   = dc_hc[20:16];
        job.mlen   = cat;
        job.status = sat ? ST_SAT : ST_OK;
      end
      MODE_AC: begin
        if (!block_closed_r) begin
          if (coef_value == 16'sd0) begin
            if (zero_run == 6'd0) begin
              job.code = eob_hc[15:0];
              job.clen = eob_hc[20:16];
              block_closed_nxt = 1'b1;
            end else if (zero_run == 6'd15) begin
              job.code = ZRL_CODE;
              job.clen = ZRL_LEN;
            end else begin
              job.status = ST_ZERO;
            end
          end else begin
            job.n_zrl  = zero_run[5:4];
            job.code   = ac_hc[15:0];
            job.clen   = ac_hc[20:16];
            job.mlen   = cat;
            job.status = sat ? ST_SAT : ST_OK;
          end
        end
      end
      MODE_EOB: begin
        if (!block_closed_r) begin
          job.code = eob_hc[15:0];
          job.clen = eob_hc[20:16];
        end
        block_closed_nxt = 1'b1;
      end
      default: begin
        job.flush = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_closed_r <= 1'b0;
    end else if (accept) begin
      block_closed_r <= block_closed_nxt;
    end
  end
endmodule

// File: hdl/cfh_back.sv
module cfh_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_empty,
  input  cfh_pkg::cfh_job_t job_in,
  output logic              job_pop,
  input  logic              res_full,
  output logic              res_push,
  output cfh_pkg::cfh_res_t res
);
  import cfh_pkg::*;

  typedef enum logic {S_IDLE, S_WORK} state_t;

  state_t state_r, state_nxt;
  cfh_job_t job_r, job_nxt;
  logic [1:0] zrl_left_r, zrl_left_nxt;
  logic code_pend_r, code_pend_nxt, mag_pend_r, mag_pend_nxt;
  logic flush_pend_r, flush_pend_nxt;
  logic [22:0] acc_r, acc_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic held_v_r, held_v_nxt;
  logic [7:0] held_r, held_nxt;
  logic app_en;
  logic [4:0] app_len;
  logic [15:0] app_bits;
  logic [22:0] app_mask;
  logic [7:0] new_byte;

  assign app_mask = (23'd1 << app_len) - 23'd1;
  assign new_byte = 8'(acc_r >> (cnt_r - 5'd8));

  // Each cycle loads a job, drains a byte, adds a segment or ends the item.
  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    zrl_left_nxt   = zrl_left_r;
    code_pend_nxt  = code_pend_r;
    mag_pend_nxt   = mag_pend_r;
    flush_pend_nxt = flush_pend_r;
    held_v_nxt     = held_v_r;
    held_nxt       = held_r;
    cnt_nxt        = cnt_r;
    acc_nxt        = acc_r;
    job_pop        = 1'b0;
    res_push       = 1'b0;
    res            = '0;
    res.status     = job_r.status;
    app_en         = 1'b0;
    app_len        = '0;
    app_bits       = '0;
    case (state_r)
      S_IDLE: begin
        if (!job_empty) begin
          job_pop        = 1'b1;
          job_nxt        = job_in;
          zrl_left_nxt   = job_in.n_zrl;
          code_pend_nxt  = (job_in.clen != 5'd0);
          mag_pend_nxt   = (job_in.mlen != 4'd0);
          flush_pend_nxt = job_in.flush;
          state_nxt      = S_WORK;
        end
      end
      S_WORK: begin
        if (cnt_r >= 5'd8) begin
          // A byte is complete; the previous one is now known not to be last.
          if (!(held_v_r && res_full)) begin
            res.data     = held_r;
            res.has_byte = 1'b1;
            res_push     = held_v_r;
            held_v_nxt   = 1'b1;
            held_nxt     = new_byte;
            cnt_nxt      = cnt_r - 5'd8;
          end
        end else if (zrl_left_r != 2'd0) begin
          app_en       = 1'b1;
          app_len      = ZRL_LEN;
          app_bits     = ZRL_CODE;
          zrl_left_nxt = zrl_left_r - 2'd1;
        end else if (code_pend_r) begin
          app_en        = 1'b1;
          app_len       = job_r.clen;
          app_bits      = job_r.code;
          code_pend_nxt = 1'b0;
        end else if (mag_pend_r) begin
          app_en       = 1'b1;
          app_len      = {1'b0, job_r.mlen};
          app_bits     = {5'd0, job_r.mag};
          mag_pend_nxt = 1'b0;
        end else if (flush_pend_r) begin
          // Pad with zeros up to the byte boundary.
          app_en         = (cnt_r != 5'd0);
          app_len        = 5'd8 - cnt_r;
          flush_pend_nxt = 1'b0;
        end else if (!res_full) begin
          res.data     = held_v_r ? held_r : 8'd0;
          res.has_byte = held_v_r;
          res.last     = 1'b1;
          res_push     = 1'b1;
          held_v_nxt   = 1'b0;
          state_nxt    = S_IDLE;
        end
        if (app_en) begin
          acc_nxt = (acc_r << app_len) | ({7'd0, app_bits} & app_mask);
          cnt_nxt = cnt_r + app_len;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      zrl_left_r   <= '0;
      code_pend_r  <= 1'b0;
      mag_pend_r   <= 1'b0;
      flush_pend_r <= 1'b0;
      held_v_r     <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      zrl_left_r   <= zrl_left_nxt;
      code_pend_r  <= code_pend_nxt;
      mag_pend_r   <= mag_pend_nxt;
      flush_pend_r <= flush_pend_nxt;
      held_v_r     <= held_v_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    acc_r  <= acc_nxt;
    held_r <= held_nxt;
  end

  // Between items fewer than eight bits are left over and no byte is held.
  a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cnt_r < 5'd8 && !held_v_r))
    else $error("back end idle with a whole byte pending");

  // The accumulator never overflows.
  a_acc_room: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 5'd23)
    else $error("bit accumulator overflow");

  // The last beat of an item returns the back end to idle.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.last) |=> (state_r == S_IDLE))
    else $error("item did not end after its last beat");
endmodule

// File: bench/tb_top.sv
module tb_top;
  import cfh_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [1:0]  in_mode;
  logic [5:0]  in_zero_run;
  logic signed [15:0] in_coef_value;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        out_has_byte;
  logic        out_last;
  logic [1:0]  out_status;

  jpeg_coefficient_huffman_encoder i_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_mode(in_mode), .in_zero_run(in_zero_run), .in_coef_value(in_coef_value),
    .empty(empty), .pop(pop), .out_byte(out_byte), .out_has_byte(out_has_byte),
    .out_last(out_last), .out_status(out_status)
  );

  // Expected result beats, oldest first.
  cfh_res_t byte_queue[$];

  // Predictor state: bit buffer and block status.
  logic [7:0] pend_bits;
  int         pend_cnt;
  bit         blk_closed;
  cfh_res_t   emit_buf[$];

  // Idling controls, in percent.
  int  send_idle_pct;
  int  pop_stall_pct;
  bit  hold_pop;
  int  errors;
  longint cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Canonical code tables built the standard way.
  logic [15:0] ac_code_tab [0:255];
  int          ac_len_tab  [0:255];
  logic [15:0] dc_code_tab [0:11];
  int          dc_len_tab  [0:11];

  task automatic build_tables();
    int counts_ac[16];
    int counts_dc[16];
    byte unsigned syms[162];
    logic [15:0] c;
    int k;
    counts_ac = '{0, 2, 1, 3, 3, 2, 4, 3, 5, 5, 4, 4, 0, 0, 1, 125};
    counts_dc = '{0, 1, 5, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0};
    syms = '{
      8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,
      8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,8'h23,8'h42,8'hb1,8'hc1,
      8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,
      8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
      8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,
      8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,
      8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,
      8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
      8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,
      8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,
      8'hd9,8'hda,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,
      8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};
    for (int i = 0; i < 256; i++) ac_len_tab[i] = 0;
    c = '0;
    k = 0;
    for (int l = 1; l <= 16; l++) begin
      for (int i = 0; i < counts_ac[l-1]; i++) begin
        ac_code_tab[syms[k]] = c;
        ac_len_tab[syms[k]] = l;
        c++;
        k++;
      end
      c = c << 1;
    end
    // DC symbols are simply 0..11 in order.
    c = '0;
    k = 0;
    for (int l = 1; l <= 16; l++) begin
      for (int i = 0; i < counts_dc[l-1]; i++) begin
        dc_code_tab[k] = c;
        dc_len_tab[k] = l;
        c++;
        k++;
      end
      c = c << 1;
    end
  endtask

  // Appends bits MSB first to the packer model.
  function automatic void pack_bits(logic [15:0] val, int len);
    cfh_res_t r;
    for (int i = len - 1; i >= 0; i--) begin
      pend_bits = {pend_bits[6:0], val[i]};
      pend_cnt++;
      if (pend_cnt == 8) begin
        r = '0;
        r.data = pend_bits;
        r.has_byte = 1'b1;
        emit_buf.push_back(r);
        pend_bits = '0;
        pend_cnt = 0;
      end
    end
  endfunction

  function automatic int size_class(int v);
    int a;
    int c;
    a = (v < 0) ? -v : v;
    c = 0;
    while (a != 0) begin
      c++;
      a = a >> 1;
    end
    return c;
  endfunction

  function automatic void pack_magnitude(int v, int cat);
    int b;
    if (cat == 0) return;
    b = (v >= 0) ? v : v + (1 << cat) - 1;
    pack_bits(16'(b), cat);
  endfunction

  function automatic void pack_ac(int sym);
    pack_bits(ac_code_tab[sym], ac_len_tab[sym]);
  endfunction

  // Predicts the result beats of one coefficient item.
  function automatic void predict_encode(logic [1:0] mode, logic [5:0] run_in,
                                         logic signed [15:0] coef);
    int v;
    int run;
    int cat;
    logic [1:0] st;
    cfh_res_t r;
    v = coef;
    run = run_in;
    st = ST_OK;
    emit_buf.delete();
    case (mode)
      MODE_DC: begin
        blk_closed = 1'b0;
        if (v > 2047) begin
          v = 2047;
          st = ST_SAT;
        end else if (v < -2047) begin
          v = -2047;
          st = ST_SAT;
        end
        cat = size_class(v);
        pack_bits(dc_code_tab[cat], dc_len_tab[cat]);
        pack_magnitude(v, cat);
      end
      MODE_AC: begin
        if (!blk_closed) begin
          if (v == 0) begin
            if (run == 0) begin
              pack_ac(SYM_EOB);
              blk_closed = 1'b1;
            end else if (run == 15) begin
              pack_ac(SYM_ZRL);
            end else begin
              st = ST_ZERO;
            end
          end else begin
            while (run > 15) begin
              pack_ac(SYM_ZRL);
              run -= 16;
            end
            if (v > 1023) begin
              v = 1023;
              st = ST_SAT;
            end else if (v < -1023) begin
              v = -1023;
              st = ST_SAT;
            end
            cat = size_class(v);
            pack_ac((run << 4) | cat);
            pack_magnitude(v, cat);
          end
        end
      end
      MODE_EOB: begin
        if (!blk_closed) pack_ac(SYM_EOB);
        blk_closed = 1'b1;
      end
      default: begin
        if (pend_cnt != 0) pack_bits(16'h0, 8 - pend_cnt);
      end
    endcase
    if (emit_buf.size() == 0) begin
      r = '0;
      emit_buf.push_back(r);
    end
    emit_buf[emit_buf.size()-1].last = 1'b1;
    foreach (emit_buf[i]) begin
      emit_buf[i].status = st;
      byte_queue.push_back(emit_buf[i]);
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    errors++;
  endtask

  // Sends one item; waits until it is accepted. Push stays high after the
  // accepting edge so that a following item can go out back to back.
  task automatic send_item(logic [1:0] mode, logic [5:0] run, logic signed [15:0] coef);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_mode <= mode;
    in_zero_run <= run;
    in_coef_value <= coef;
    predict_encode(mode, run, coef);
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= !hold_pop && !(pop_stall_pct > 0 && $urandom_range(99) < pop_stall_pct);
    end
  end

  // Checks each accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    cfh_res_t w;
    if (rst_n && pop && !empty) begin
      if (byte_queue.size() == 0) begin
        report_mismatch("unexpected beat", out_byte, 0);
      end else begin
        w = byte_queue.pop_front();
        if (out_byte != w.data) report_mismatch("out_byte", out_byte, w.data);
        if (out_has_byte != w.has_byte)
          report_mismatch("out_has_byte", out_has_byte, w.has_byte);
        if (out_last != w.last) report_mismatch("out_last", out_last, w.last);
        if (out_status != w.status) report_mismatch("out_status", out_status, w.status);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_drained();
    push <= 1'b0;
    while (byte_queue.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send_random(int count);
    int kind;
    logic signed [15:0] v;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      case ($urandom_range(3))
        0: v = 16'($urandom);
        1: v = 16'($signed(16'($urandom_range(2047))) * ($urandom_range(1) ? 1 : -1));
        2: v = 16'($signed(16'($urandom_range(15))) - 8);
        default: v = 16'($signed(16'($urandom_range(300))) - 150);
      endcase
      if (kind < 10) send_item(MODE_DC, 6'($urandom), v);
      else if (kind < 75) send_item(MODE_AC, ($urandom_range(3) == 0) ? 6'($urandom)
                                              : 6'($urandom_range(15)), v);
      else if (kind < 82) send_item(MODE_AC, 6'($urandom), 16'sd0);
      else if (kind < 92) send_item(MODE_EOB, 6'($urandom), v);
      else send_item(MODE_FLUSH, 6'($urandom), v);
    end
  endtask

  // Well-formed blocks: DC, a few AC pairs, an end of block.
  task automatic send_blocks(int nblocks);
    for (int b = 0; b < nblocks; b++) begin
      send_item(MODE_DC, 6'($urandom), 16'($signed(16'($urandom_range(600))) - 300));
      repeat ($urandom_range(6, 1))
        send_item(MODE_AC, 6'($urandom_range(20)),
                  16'($signed(16'($urandom_range(80))) - 40 | 1));
      send_item(MODE_EOB, '0, '0);
    end
  endtask

  task automatic test_directed();
    send_item(MODE_DC, 6'd0, 16'sd0);
    send_item(MODE_AC, 6'd63, 16'sh7FFF);
    send_item(MODE_AC, 6'd0, -16'sd32768);
    send_item(MODE_AC, 6'd15, 16'sd0);
    send_item(MODE_AC, 6'd7, 16'sd0);
    send_item(MODE_AC, 6'd0, 16'sd1023);
    send_item(MODE_AC, 6'd1, -16'sd1023);
    send_item(MODE_AC, 6'd0, 16'sd0);
    send_item(MODE_AC, 6'd3, 16'sd5);
    send_item(MODE_EOB, 6'd0, 16'sd0);
    send_item(MODE_FLUSH, 6'h3F, -16'sd1);
    send_item(MODE_FLUSH, 6'd0, 16'sd0);
    send_item(MODE_DC, 6'h2A, 16'sd2047);
    send_item(MODE_DC, 6'h15, -16'sd2048);
    send_item(MODE_DC, 6'd0, 16'sh7FFF);
    send_item(MODE_DC, 6'd0, -16'sd1);
    send_item(MODE_AC, 6'd47, -16'sd1);
    send_item(MODE_EOB, 6'd0, 16'sd0);
    send_item(MODE_EOB, 6'd0, 16'sd0);
    send_item(MODE_FLUSH, 6'd0, 16'sd0);
    wait_drained();
  endtask

  task automatic test_no_idling();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    send_blocks(6);
    send_random(30);
  endtask

  task automatic test_sender_idle();
    send_idle_pct = 56;
    pop_stall_pct = 0;
    send_random(50);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct = 0;
    pop_stall_pct = 56;
    send_blocks(5);
    send_random(40);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 13;
    pop_stall_pct = 13;
    send_random(50);
    send_item(MODE_FLUSH, '0, '0);
  endtask

  // Receiver holds off while the sender keeps pushing, so the block backs up.
  task automatic test_backpressure();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    fork
      begin
        hold_pop <= 1'b1;
        repeat (300) @(posedge clk);
        hold_pop <= 1'b0;
      end
      send_blocks(4);
    join
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_mode = MODE_DC;
    in_zero_run = '0;
    in_coef_value = '0;
    hold_pop = 1'b0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    errors = 0;
    cycles = 0;
    pend_bits = '0;
    pend_cnt = 0;
    blk_closed = 1'b0;
    build_tables();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    wait_drained();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/cfh_pkg.sv
hdl/cfh_fifo.sv
hdl/cfh_front.sv
hdl/cfh_back.sv
hdl/jpeg_coefficient_huffman_encoder.sv
bench/tb_top.sv
